// ===== rtl/core/evr_pkg.sv =====
// ----------------------------------------------------------------------------
// evr_pkg
// Shared types and codes for the vertex remap table: coordinates, stored
// vertex layout, squared distance and item op codes.
// ----------------------------------------------------------------------------
package evr_pkg;

  localparam int CoordW = 20;
  localparam int DiffW  = CoordW + 1;
  localparam int DistW  = 2 * DiffW;
  localparam int OutIdxW = 10;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [DistW-1:0]         dist_t;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } vert_t;

  typedef struct packed {
    logic  vld;
    dist_t sq_sum;
  } dist_res_t;

endpackage

// ===== rtl/core/evr_store.sv =====
// ----------------------------------------------------------------------------
// evr_store
// Reference vertex memory: one write port, one read port with registered
// read data, read index and read valid.
// ----------------------------------------------------------------------------
module evr_store #(
  parameter int DEPTH = 1024,
  parameter int IDX_W = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  evr_pkg::vert_t   wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic             rd_vld_r,
  output logic [IDX_W-1:0] rd_idx_r,
  output evr_pkg::vert_t   rd_data_r
);
  import evr_pkg::*;

  vert_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_idx_r  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
    end
  end

endmodule

// ===== rtl/core/evr_dist.sv =====
// ----------------------------------------------------------------------------
// evr_dist
// Squared distance unit: difference, square and sum stages, one stored
// vertex per cycle against the held query position.
// ----------------------------------------------------------------------------
module evr_dist #(
  parameter int IDX_W = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [IDX_W-1:0]    in_idx,
  input  evr_pkg::vert_t      ref_pos,
  input  evr_pkg::vert_t      qry_pos,
  output evr_pkg::dist_res_t  res,
  output logic [IDX_W-1:0]    res_idx,
  output logic                busy
);
  import evr_pkg::*;

  logic signed [DiffW-1:0] dx_r, dy_r, dz_r;
  logic signed [DistW-1:0] sx_r, sy_r, sz_r;
  dist_t                   sum_r;
  logic [IDX_W-1:0]        idx1_r, idx2_r, idx3_r;
  logic                    v1_r, v2_r, v3_r;

  always_ff @(posedge clk) begin
    dx_r   <= {qry_pos.x[CoordW-1], qry_pos.x} - {ref_pos.x[CoordW-1], ref_pos.x};
    dy_r   <= {qry_pos.y[CoordW-1], qry_pos.y} - {ref_pos.y[CoordW-1], ref_pos.y};
    dz_r   <= {qry_pos.z[CoordW-1], qry_pos.z} - {ref_pos.z[CoordW-1], ref_pos.z};
    idx1_r <= in_idx;
    sx_r   <= dx_r * dx_r;
    sy_r   <= dy_r * dy_r;
    sz_r   <= dz_r * dz_r;
    idx2_r <= idx1_r;
    sum_r  <= $unsigned(sx_r) + $unsigned(sy_r) + $unsigned(sz_r);
    idx3_r <= idx2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign res.vld    = v3_r;
  assign res.sq_sum = sum_r;
  assign res_idx    = idx3_r;
  assign busy       = v1_r | v2_r | v3_r;

endmodule

// ===== rtl/core/evr_min.sv =====
// ----------------------------------------------------------------------------
// evr_min
// Running minimum tracker: keeps the least distance seen and the index of
// its first occurrence.
// ----------------------------------------------------------------------------
module evr_min #(
  parameter int IDX_W = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clr,
  input  evr_pkg::dist_res_t res,
  input  logic [IDX_W-1:0]   res_idx,
  output logic               have_r,
  output evr_pkg::dist_t     best_r,
  output logic [IDX_W-1:0]   best_idx_r
);
  import evr_pkg::*;

  logic take;

  assign take = res.vld && (!have_r || (res.sq_sum < best_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (clr) begin
      have_r <= 1'b0;
    end else if (take) begin
      have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !clr) begin
      best_r     <= res.sq_sum;
      best_idx_r <= res_idx;
    end
  end

endmodule

// ===== rtl/core/exact_or_nearest_vertex_remap.sv =====
// ----------------------------------------------------------------------------
// exact_or_nearest_vertex_remap
// Reference vertex table with exact-or-nearest lookup.
// ----------------------------------------------------------------------------
// One word at a time. A clear, a load or an unused op passes from accept
// to result through the execute and output states. A query scans the
// stored vertices through one memory read port and one distance pipeline,
// one vertex per cycle, then waits for the pipeline to drain before its
// result. An exact match is a stored vertex at distance zero, so one scan
// serves both the exact and the nearest answer.
// The input is taken again once the result sits in the output register.
// ----------------------------------------------------------------------------
module exact_or_nearest_vertex_remap #(
  parameter int MAX_REF_VERTS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // pos_x[19:0], pos_y[39:20], pos_z[59:40]
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // ref_index[9:0]
  output logic [2:0]  out_tuser   // matched_exactly[0], all_exact_so_far[1], table_full[2]
);
  import evr_pkg::*;

  localparam int IDX_W = (MAX_REF_VERTS > 1) ? $clog2(MAX_REF_VERTS) : 1;
  localparam int CNT_W = $clog2(MAX_REF_VERTS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REF_VERTS);

  typedef enum logic [2:0] {ST_IDLE, ST_EXEC, ST_SCAN, ST_DRAIN, ST_OUT} state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   addr_r, addr_nxt;
  logic               flag_r, flag_nxt;
  logic [1:0]         op_r, op_nxt;
  vert_t              pos_r, pos_nxt;
  logic [OutIdxW-1:0] res_idx_r, res_idx_nxt;
  logic               res_exact_r, res_exact_nxt;
  logic               res_full_r, res_full_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic [OutIdxW-1:0] out_idx_r, out_idx_nxt;
  logic               out_exact_r, out_exact_nxt;
  logic               out_flag_r, out_flag_nxt;
  logic               out_full_r, out_full_nxt;

  logic               wr_en, rd_en, min_clr;
  logic               rd_vld;
  logic [IDX_W-1:0]   rd_idx;
  vert_t              rd_data;
  dist_res_t          dres;
  logic [IDX_W-1:0]   dres_idx;
  logic               dist_busy;
  logic               min_have;
  dist_t              min_best;
  logic [IDX_W-1:0]   min_idx;
  logic [31:0]        cnt_ext, min_idx_ext;
  logic               qry_exact;

  assign cnt_ext     = 32'(count_r);
  assign min_idx_ext = 32'(min_idx);
  assign qry_exact   = min_have && (min_best == '0);

  assign wr_en   = (state_r == ST_EXEC) && (op_r == OP_LOAD) && (count_r < MAX_CNT);
  assign rd_en   = (state_r == ST_SCAN) && (addr_r < count_r);
  assign min_clr = (state_r == ST_EXEC) && (op_r == OP_QUERY);

  evr_store #(.DEPTH(MAX_REF_VERTS), .IDX_W(IDX_W)) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_addr   (count_r[IDX_W-1:0]),
    .wr_data   (pos_r),
    .rd_en     (rd_en),
    .rd_addr   (addr_r[IDX_W-1:0]),
    .rd_vld_r  (rd_vld),
    .rd_idx_r  (rd_idx),
    .rd_data_r (rd_data)
  );

  evr_dist #(.IDX_W(IDX_W)) u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (rd_vld),
    .in_idx  (rd_idx),
    .ref_pos (rd_data),
    .qry_pos (pos_r),
    .res     (dres),
    .res_idx (dres_idx),
    .busy    (dist_busy)
  );

  evr_min #(.IDX_W(IDX_W)) u_min (
    .clk        (clk),
    .rst_n      (rst_n),
    .clr        (min_clr),
    .res        (dres),
    .res_idx    (dres_idx),
    .have_r     (min_have),
    .best_r     (min_best),
    .best_idx_r (min_idx)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    addr_nxt      = addr_r;
    flag_nxt      = flag_r;
    op_nxt        = op_r;
    pos_nxt       = pos_r;
    res_idx_nxt   = res_idx_r;
    res_exact_nxt = res_exact_r;
    res_full_nxt  = res_full_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_idx_nxt   = out_idx_r;
    out_exact_nxt = out_exact_r;
    out_flag_nxt  = out_flag_r;
    out_full_nxt  = out_full_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          pos_nxt   = vert_t'(in_tdata[3*CoordW-1:0]);
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_idx_nxt   = '0;
        res_exact_nxt = 1'b0;
        res_full_nxt  = 1'b0;
        state_nxt     = ST_OUT;
        case (op_r)
          OP_CLEAR: begin
            count_nxt = '0;
            flag_nxt  = 1'b1;
          end
          OP_LOAD: begin
            if (count_r < MAX_CNT) begin
              res_idx_nxt = cnt_ext[OutIdxW-1:0];
              count_nxt   = count_r + 1'b1;
            end else begin
              res_full_nxt = 1'b1;
            end
          end
          OP_QUERY: begin
            addr_nxt  = '0;
            state_nxt = ST_SCAN;
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        if (rd_en) begin
          addr_nxt = addr_r + 1'b1;
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld && !dist_busy) begin
          res_idx_nxt   = min_have ? min_idx_ext[OutIdxW-1:0] : '0;
          res_exact_nxt = qry_exact;
          flag_nxt      = flag_r && qry_exact;
          state_nxt     = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt   = 1'b1;
          out_idx_nxt   = res_idx_r;
          out_exact_nxt = res_exact_r;
          out_flag_nxt  = flag_r;
          out_full_nxt  = res_full_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      addr_r    <= '0;
      flag_r    <= 1'b1;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      addr_r    <= addr_nxt;
      flag_r    <= flag_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    pos_r       <= pos_nxt;
    res_idx_r   <= res_idx_nxt;
    res_exact_r <= res_exact_nxt;
    res_full_r  <= res_full_nxt;
    out_idx_r   <= out_idx_nxt;
    out_exact_r <= out_exact_nxt;
    out_flag_r  <= out_flag_nxt;
    out_full_r  <= out_full_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(16-OutIdxW){1'b0}}, out_idx_r};
  assign out_tuser  = {out_full_r, out_flag_r, out_exact_r};

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("reference count above table depth");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) && (op_r == OP_LOAD) |=>
      res_full_r == ($past(count_r) == MAX_CNT))
    else $error("load dropped while table has room");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> addr_r < count_r && state_r == ST_SCAN)
    else $error("scan read beyond stored vertices");

  a_write_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !rd_vld && !dist_busy)
    else $error("table write while scan pipeline busy");
`endif

endmodule
